### rtl/spct_pkg.sv
// Shared types and constants for the shape pair collision test.
package spct_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_COORDS = 10;
  localparam int IN_TDATA_W = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [IN_TUSER_W-1:0] {
    MODE_BOX     = 2'd0,
    MODE_CIRCLE  = 2'd1,
    MODE_SEGMENT = 2'd2,
    MODE_MIXED   = 2'd3
  } mode_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    mode_t  mode;
    coord_t offset_x;
    coord_t offset_y;
    coord_t first_a_x;
    coord_t first_a_y;
    coord_t first_b_x;
    coord_t first_b_y;
    coord_t second_a_x;
    coord_t second_a_y;
    coord_t second_b_x;
    coord_t second_b_y;
  } item_t;

endpackage

### rtl/spct_box.sv
// Strict axis-aligned box overlap test.
module spct_box (
  input  spct_pkg::item_t item,
  output logic            hit
);

  localparam int W = spct_pkg::COORD_BITS + 1;

  logic signed [W-1:0] min1x;
  logic signed [W-1:0] min1y;
  logic signed [W-1:0] max1x;
  logic signed [W-1:0] max1y;

  assign min1x = W'(item.first_a_x) + W'(item.offset_x);
  assign min1y = W'(item.first_a_y) + W'(item.offset_y);
  assign max1x = W'(item.first_b_x) + W'(item.offset_x);
  assign max1y = W'(item.first_b_y) + W'(item.offset_y);

  assign hit = (min1x < W'(item.second_b_x)) && (max1x > W'(item.second_a_x)) &&
               (min1y < W'(item.second_b_y)) && (max1y > W'(item.second_a_y));

endmodule

### rtl/spct_circle.sv
// Circle overlap test on squared distance against squared radius sum.
module spct_circle (
  input  spct_pkg::item_t item,
  output logic            hit
);

  localparam int C  = spct_pkg::COORD_BITS;
  localparam int RW = C + 1;
  localparam int SW = 2 * C + 2;

  logic signed [RW-1:0] rsum;
  logic signed [SW-1:0] sq_x;
  logic signed [SW-1:0] sq_y;
  logic signed [SW-1:0] sq_r;
  logic signed [SW-1:0] dist_sq;

  assign rsum    = RW'(item.first_a_x) + RW'(item.second_a_x);
  assign sq_x    = SW'(item.offset_x) * SW'(item.offset_x);
  assign sq_y    = SW'(item.offset_y) * SW'(item.offset_y);
  assign sq_r    = SW'(rsum) * SW'(rsum);
  assign dist_sq = sq_x + sq_y;
  assign hit     = dist_sq < sq_r;

endmodule

### rtl/spct_segment.sv
// Segment crossing test with exact integer cross products.
module spct_segment (
  input  spct_pkg::item_t item,
  output logic            hit
);

  localparam int C  = spct_pkg::COORD_BITS;
  localparam int DW = C + 1;
  localparam int EW = C + 2;
  localparam int PW = 2 * C + 4;

  function automatic logic in_unit(input logic signed [PW-1:0] n,
                                   input logic signed [PW-1:0] d);
    logic r;
    if (d > PW'(0)) begin
      r = (n >= PW'(0)) && (n <= d);
    end else begin
      r = (n <= PW'(0)) && (n >= d);
    end
    return r;
  endfunction

  logic signed [DW-1:0] d2x;
  logic signed [DW-1:0] d2y;
  logic signed [DW-1:0] d4x;
  logic signed [DW-1:0] d4y;
  logic signed [EW-1:0] ex;
  logic signed [EW-1:0] ey;
  logic signed [PW-1:0] u0;
  logic signed [PW-1:0] u1;
  logic signed [PW-1:0] t0;
  logic signed [PW-1:0] t1;
  logic signed [PW-1:0] s0;
  logic signed [PW-1:0] s1;
  logic signed [PW-1:0] under;
  logic signed [PW-1:0] tn;
  logic signed [PW-1:0] sn;

  // The offset moves both ends of segment one, so it cancels in its direction.
  assign d2x = DW'(item.first_b_x) - DW'(item.first_a_x);
  assign d2y = DW'(item.first_b_y) - DW'(item.first_a_y);
  assign d4x = DW'(item.second_b_x) - DW'(item.second_a_x);
  assign d4y = DW'(item.second_b_y) - DW'(item.second_a_y);
  assign ex  = EW'(item.first_a_x) + EW'(item.offset_x) - EW'(item.second_a_x);
  assign ey  = EW'(item.first_a_y) + EW'(item.offset_y) - EW'(item.second_a_y);

  assign u0 = PW'(d4y) * PW'(d2x);
  assign u1 = PW'(d4x) * PW'(d2y);
  assign t0 = PW'(d4y) * PW'(ex);
  assign t1 = PW'(d4x) * PW'(ey);
  assign s0 = PW'(d2y) * PW'(ex);
  assign s1 = PW'(d2x) * PW'(ey);

  assign under = u0 - u1;
  assign tn    = t0 - t1;
  assign sn    = s0 - s1;

  assign hit = (under != PW'(0)) && in_unit(tn, under) && in_unit(sn, under) &&
               !((tn == PW'(0)) && (sn == PW'(0)));

endmodule

### rtl/shape_pair_collision_test.sv
// Top level of the shape pair collision test with input and result registers.
// Each input item describes two colliders of one kind (boxes, circles or segments)
// and the offset of the first from the second (the mixed mode always gives no hit);
// the block returns one item whose bit 0 is the hit flag. The block takes one item
// every cycle while the output is not stalled. The item is registered, the box,
// circle and segment tests run in parallel in one combinational stage, and the
// selected flag is registered at the output before it is offered. Both stages hold
// under backpressure: while a result waits to be taken, the input accepts one more
// item and then stalls until the output drains.
module shape_pair_collision_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // offset_x, offset_y, first_a_x, first_a_y, first_b_x, first_b_y,
  // second_a_x, second_a_y, second_b_x, second_b_y
  input  logic [spct_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode
  input  logic [spct_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit
  output logic [spct_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CB = spct_pkg::COORD_BITS;

  spct_pkg::item_t item_in;
  spct_pkg::item_t item_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            hit_r;
  logic            hit_nxt;
  logic            out_adv;
  logic            box_hit;
  logic            circle_hit;
  logic            segment_hit;

  always_comb begin
    item_in.mode       = spct_pkg::mode_t'(in_tuser);
    item_in.offset_x   = in_tdata[0*CB +: CB];
    item_in.offset_y   = in_tdata[1*CB +: CB];
    item_in.first_a_x  = in_tdata[2*CB +: CB];
    item_in.first_a_y  = in_tdata[3*CB +: CB];
    item_in.first_b_x  = in_tdata[4*CB +: CB];
    item_in.first_b_y  = in_tdata[5*CB +: CB];
    item_in.second_a_x = in_tdata[6*CB +: CB];
    item_in.second_a_y = in_tdata[7*CB +: CB];
    item_in.second_b_x = in_tdata[8*CB +: CB];
    item_in.second_b_y = in_tdata[9*CB +: CB];
  end

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
    if (out_adv && s1_valid_r) begin
      hit_r <= hit_nxt;
    end
  end

  spct_box u_box (
    .item (item_r),
    .hit  (box_hit)
  );

  spct_circle u_circle (
    .item (item_r),
    .hit  (circle_hit)
  );

  spct_segment u_segment (
    .item (item_r),
    .hit  (segment_hit)
  );

  always_comb begin
    unique case (item_r.mode)
      spct_pkg::MODE_BOX:     hit_nxt = box_hit;
      spct_pkg::MODE_CIRCLE:  hit_nxt = circle_hit;
      spct_pkg::MODE_SEGMENT: hit_nxt = segment_hit;
      spct_pkg::MODE_MIXED:   hit_nxt = 1'b0;
      default:                hit_nxt = 1'b0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(spct_pkg::OUT_TDATA_W-1){1'b0}}, hit_r};

endmodule

### rtl/spct_checker.sv
// Port-level checker for the shape pair collision test and its bind.
module spct_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("Result appeared without an accepted item two cycles earlier.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("Input stalled while the output drains.");

  a_pad_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[spct_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("Result padding bits not zero.");

endmodule

bind shape_pair_collision_test spct_checker u_spct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
